>>> rtl/cfl_tmr_pkg.sv
// ============================================================================
// cfl_tmr_pkg
// Shared widths, codes and state type of the Courant time step reduction.
// ============================================================================
package cfl_tmr_pkg;

    // fixed point format and default dimension count
    localparam int FRACTION_BITS  = 16;
    localparam int DIMENSIONS_DEF = 3;

    // field widths
    localparam int H_W   = 31;                  // smoothing length, sound speed
    localparam int G_W   = 32;                  // strain rate and gravity terms
    localparam int CFL_W = 17;                  // Courant factor register
    localparam int ABS_W = G_W + 1;             // |trace| of up to three terms

    // datapath widths
    localparam int MUL_A_W = H_W + FRACTION_BITS;              // parallel operand
    localparam int MUL_B_W = ABS_W;                            // serial operand
    localparam int PROD_W  = 64;                               // product word
    localparam int DEN_W   = H_W + ABS_W - FRACTION_BITS + 1;  // Courant divisor
    localparam int NUM_W   = H_W + 2 * FRACTION_BITS;          // dividend word
    localparam int ROOT_W  = 64;                               // radicand
    localparam int ROOT_O_W = ROOT_W / 2;                      // root

    localparam logic [H_W-1:0]   OUT_MAX   = {H_W{1'b1}};
    localparam logic [CFL_W-1:0] CFL_RESET = CFL_W'(19661);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CFL_FACTOR   = 1'b0,
        REG_SELF_GRAVITY = 1'b1
    } t_reg_idx;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TR_MUL,
        ST_TR_DIV,
        ST_TR_SCALE,
        ST_G_SQUARE,
        ST_G_ROOT,
        ST_G_DIV,
        ST_G_ROOT2,
        ST_G_SCALE,
        ST_FINISH
    } t_state;

endpackage

>>> rtl/cfl_tmr_mul.sv
// ============================================================================
// cfl_tmr_mul
// Bit-serial shift-add multiplier: one bit of the serial operand per cycle.
// ============================================================================
module cfl_tmr_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [cfl_tmr_pkg::MUL_A_W-1:0] i_a,
    input  logic [cfl_tmr_pkg::MUL_B_W-1:0] i_b,
    input  logic [cfl_tmr_pkg::PROD_W-1:0]  i_init,
    output logic                           o_done,
    output logic [cfl_tmr_pkg::PROD_W-1:0]  o_prod
);
    import cfl_tmr_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W + 1);

    logic [PROD_W-1:0]  r_acc;
    logic [PROD_W-1:0]  r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;

    // load operands, then add one shifted partial product per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(MUL_B_W);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_init;
            r_a   <= PROD_W'(i_a);
            r_b   <= i_b;
        end else if (r_cnt != '0) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

>>> rtl/cfl_tmr_div.sv
// ============================================================================
// cfl_tmr_div
// Restoring divider: one quotient bit per cycle, truncating.
// ============================================================================
module cfl_tmr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cfl_tmr_pkg::NUM_W-1:0] i_num,
    input  logic [cfl_tmr_pkg::DEN_W-1:0] i_den,
    output logic                          o_done,
    output logic [cfl_tmr_pkg::NUM_W-1:0] o_quot
);
    import cfl_tmr_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [DEN_W:0]   w_trial;
    logic             w_fit;

    // shift in the next dividend bit and try the subtraction
    always_comb begin
        w_trial = {r_rem, r_q[NUM_W-1]};
        w_fit   = (w_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= i_num;
        end else if (r_cnt != '0) begin
            r_rem <= w_fit ? DEN_W'(w_trial - {1'b0, r_den}) : DEN_W'(w_trial);
            r_q   <= {r_q[NUM_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> rtl/cfl_tmr_sqrt.sv
// ============================================================================
// cfl_tmr_sqrt
// Digit-by-digit integer square root: one root bit per cycle, truncating.
// ============================================================================
module cfl_tmr_sqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [cfl_tmr_pkg::ROOT_W-1:0]   i_x,
    output logic                             o_done,
    output logic [cfl_tmr_pkg::ROOT_O_W-1:0] o_root
);
    import cfl_tmr_pkg::*;

    localparam int CNT_W = $clog2(ROOT_O_W + 1);

    logic [ROOT_W-1:0] r_x;
    logic [ROOT_W-1:0] r_res;
    logic [ROOT_W-1:0] r_bit;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [ROOT_W-1:0] w_sum;

    assign w_sum = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(ROOT_O_W);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    // try the next root bit, then move two radicand bits down
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_res <= '0;
            r_bit <= ROOT_W'(1) << (ROOT_W - 2);
        end else if (r_cnt != '0) begin
            if (r_x >= w_sum) begin
                r_x   <= r_x - w_sum;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_O_W-1:0];

endmodule

>>> rtl/cfl_timestep_min_reduction.sv
// ============================================================================
// cfl_timestep_min_reduction
// Running minimum of the SPH Courant and gravity time step bounds per sweep.
// ============================================================================
//  channel  | handshake                 | words
//  ---------+---------------------------+------------------------------------
//  in       | i_in_valid / o_in_ready   | one particle
//  out      | o_out_valid / i_out_ready | time step and flag, per last particle
//  cfg      | i_cfg_we                  | cfl_factor, self_gravity_enable
//
//  Each particle runs to completion before the next is accepted; with
//  self-gravity on it adds DIMENSIONS squarings and a root, then, for a
//  nonzero root, a division, a second root and a scale. Time is set by the
//  bit-serial units: multiplier 33, divider 63, square root 32 steps.
//  Reset is synchronous and clears the sequencer, minimum and output slot.
//  The next particle is taken while a result waits on out; a last particle
//  holds in its final step until the output slot is free.
module cfl_timestep_min_reduction #(
    parameter int DIMENSIONS = cfl_tmr_pkg::DIMENSIONS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [cfl_tmr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cfl_tmr_pkg::CFL_W-1:0]     i_cfg_data,
    // particle words
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [cfl_tmr_pkg::H_W-1:0]       i_smoothing_length,
    input  logic [cfl_tmr_pkg::H_W-1:0]       i_sound_speed,
    input  logic signed [cfl_tmr_pkg::G_W-1:0] i_strain_rate_x,
    input  logic signed [cfl_tmr_pkg::G_W-1:0] i_strain_rate_y,
    input  logic signed [cfl_tmr_pkg::G_W-1:0] i_strain_rate_z,
    input  logic signed [cfl_tmr_pkg::G_W-1:0] i_gravity_x,
    input  logic signed [cfl_tmr_pkg::G_W-1:0] i_gravity_y,
    input  logic signed [cfl_tmr_pkg::G_W-1:0] i_gravity_z,
    input  logic                              i_last_particle,
    // result words
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [cfl_tmr_pkg::H_W-1:0]       o_time_step,
    output logic                              o_no_finite_bound
);
    import cfl_tmr_pkg::*;

    localparam int GCNT_W = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;

    // configuration
    logic [CFL_W-1:0] r_cfl;
    logic             r_sg_en;

    // sequencer
    t_state            r_state, n_state;
    logic              r_go, n_go;
    logic [GCNT_W-1:0] r_gcnt;

    // particle operands
    logic [H_W-1:0]   r_h;
    logic [H_W-1:0]   r_cs;
    logic [ABS_W-1:0] r_atr;
    logic [G_W-1:0]   r_ag [DIMENSIONS];
    logic             r_last;
    logic [DEN_W-1:0] r_den;

    // reduction and output slot
    logic [G_W-1:0]   r_min;
    logic             r_seen;
    logic             r_out_valid;
    logic [H_W-1:0]   r_out_ts;
    logic             r_out_nfb;

    // unit connections
    logic               w_mul_start, w_mul_done;
    logic               w_div_start, w_div_done;
    logic               w_sqrt_start, w_sqrt_done;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [PROD_W-1:0]  w_mul_init;
    logic [PROD_W-1:0]  w_prod;
    logic [NUM_W-1:0]   w_num;
    logic [DEN_W-1:0]   w_div_den;
    logic [NUM_W-1:0]   w_quot;
    logic [ROOT_W-1:0]  w_rad;
    logic [ROOT_O_W-1:0] w_root;

    logic               w_accept;
    logic               w_emit;
    logic               w_take;
    logic [DEN_W-1:0]   w_den;
    logic [PROD_W-FRACTION_BITS-1:0] w_scaled;
    logic [H_W-1:0]     w_bound;
    logic signed [G_W+1:0] w_trace;
    logic [G_W+1:0]     w_trace_abs;
    logic signed [G_W-1:0] w_sr [3];
    logic signed [G_W-1:0] w_gv [3];

    // trace magnitude and gravity terms of the offered particle
    always_comb begin
        w_sr[0] = i_strain_rate_x;
        w_sr[1] = i_strain_rate_y;
        w_sr[2] = i_strain_rate_z;
        w_gv[0] = i_gravity_x;
        w_gv[1] = i_gravity_y;
        w_gv[2] = i_gravity_z;
        w_trace = '0;
        for (int d = 0; d < DIMENSIONS; d++) begin
            w_trace = w_trace + (G_W+2)'(w_sr[d]);
        end
        w_trace_abs = w_trace[G_W+1] ? (G_W+2)'(-w_trace) : (G_W+2)'(w_trace);
    end

    // divisor of the Courant bound and the scaled, saturated bound
    always_comb begin
        w_den    = DEN_W'(r_cs) + DEN_W'(w_prod >> FRACTION_BITS);
        w_scaled = w_prod[PROD_W-1:FRACTION_BITS];
        w_bound  = (w_scaled > (PROD_W-FRACTION_BITS)'(OUT_MAX)) ?
                   OUT_MAX : w_scaled[H_W-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_go    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_TR_MUL;
                    n_go    = 1'b1;
                end
            end
            ST_TR_MUL: begin
                if (w_mul_done) begin
                    n_go = 1'b1;
                    if (w_den != '0) begin
                        n_state = ST_TR_DIV;
                    end else if (r_sg_en) begin
                        n_state = ST_G_SQUARE;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_TR_DIV: begin
                if (w_div_done) begin
                    n_state = ST_TR_SCALE;
                    n_go    = 1'b1;
                end
            end
            ST_TR_SCALE: begin
                if (w_mul_done) begin
                    n_state = r_sg_en ? ST_G_SQUARE : ST_FINISH;
                    n_go    = 1'b1;
                end
            end
            ST_G_SQUARE: begin
                if (w_mul_done) begin
                    n_go = 1'b1;
                    if (r_gcnt == GCNT_W'(DIMENSIONS - 1)) begin
                        n_state = ST_G_ROOT;
                    end
                end
            end
            ST_G_ROOT: begin
                if (w_sqrt_done) begin
                    n_state = (w_root != '0) ? ST_G_DIV : ST_FINISH;
                    n_go    = 1'b1;
                end
            end
            ST_G_DIV: begin
                if (w_div_done) begin
                    n_state = ST_G_ROOT2;
                    n_go    = 1'b1;
                end
            end
            ST_G_ROOT2: begin
                if (w_sqrt_done) begin
                    n_state = ST_G_SCALE;
                    n_go    = 1'b1;
                end
            end
            ST_G_SCALE: begin
                if (w_mul_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_last || !r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // unit strobes and operand selection
    always_comb begin
        w_mul_start  = 1'b0;
        w_div_start  = 1'b0;
        w_sqrt_start = 1'b0;
        w_mul_a      = '0;
        w_mul_b      = '0;
        w_mul_init   = '0;
        w_num        = '0;
        w_div_den    = '0;
        w_rad        = '0;
        w_take       = 1'b0;
        w_emit       = 1'b0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_TR_MUL: begin
                w_mul_start = r_go;
                w_mul_a     = MUL_A_W'(r_h);
                w_mul_b     = r_atr;
            end
            ST_TR_DIV: begin
                w_div_start = r_go;
                w_num       = NUM_W'(r_h) << FRACTION_BITS;
                w_div_den   = r_den;
            end
            ST_TR_SCALE: begin
                w_mul_start = r_go;
                w_mul_a     = w_quot[MUL_A_W-1:0];
                w_mul_b     = MUL_B_W'(r_cfl);
                w_take      = w_mul_done;
            end
            ST_G_SQUARE: begin
                w_mul_start = r_go;
                w_mul_a     = MUL_A_W'(r_ag[r_gcnt]);
                w_mul_b     = MUL_B_W'(r_ag[r_gcnt]);
                w_mul_init  = (r_gcnt == '0) ? '0 : w_prod;
            end
            ST_G_ROOT: begin
                w_sqrt_start = r_go;
                w_rad        = w_prod;
            end
            ST_G_DIV: begin
                w_div_start = r_go;
                w_num       = NUM_W'(r_h) << (2 * FRACTION_BITS);
                w_div_den   = DEN_W'(w_root);
            end
            ST_G_ROOT2: begin
                w_sqrt_start = r_go;
                w_rad        = ROOT_W'(w_quot);
            end
            ST_G_SCALE: begin
                w_mul_start = r_go;
                w_mul_a     = MUL_A_W'(w_root);
                w_mul_b     = MUL_B_W'(r_cfl);
                w_take      = w_mul_done;
            end
            ST_FINISH: begin
                w_emit = r_last && (!r_out_valid || i_out_ready);
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfl   <= CFL_RESET;
            r_sg_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_CFL_FACTOR:   r_cfl   <= i_cfg_data;
                REG_SELF_GRAVITY: r_sg_en <= i_cfg_data[0];
                default:          r_cfl   <= r_cfl;
            endcase
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_go    <= 1'b0;
            r_gcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            if (r_state != ST_G_SQUARE) begin
                r_gcnt <= '0;
            end else if (w_mul_done) begin
                r_gcnt <= r_gcnt + 1'b1;
            end
        end
    end

    // capture the particle and the Courant divisor
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_h    <= i_smoothing_length;
            r_cs   <= i_sound_speed;
            r_atr  <= w_trace_abs[ABS_W-1:0];
            r_last <= i_last_particle;
            for (int d = 0; d < DIMENSIONS; d++) begin
                r_ag[d] <= w_gv[d][G_W-1] ? G_W'(-w_gv[d]) : G_W'(w_gv[d]);
            end
        end
        if (r_state == ST_TR_MUL && w_mul_done) begin
            r_den <= w_den;
        end
    end

    // running minimum; restart once the sweep result is out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= '1;
            r_seen <= 1'b0;
        end else if (w_emit) begin
            r_min  <= '1;
            r_seen <= 1'b0;
        end else if (w_take) begin
            if (G_W'(w_bound) < r_min) begin
                r_min <= G_W'(w_bound);
            end
            r_seen <= 1'b1;
        end
    end

    // output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_ts  <= r_seen ? r_min[H_W-1:0] : OUT_MAX;
            r_out_nfb <= !r_seen;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_time_step       = r_out_ts;
    assign o_no_finite_bound = r_out_nfb;

    cfl_tmr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .i_init  (w_mul_init),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    cfl_tmr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    cfl_tmr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_x     (w_rad),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

endmodule

>>> rtl/cfl_tmr_chk.sv
// ============================================================================
// cfl_tmr_chk
// Port-level checks of the time step reduction, bound to the top level.
// ============================================================================
module cfl_tmr_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [cfl_tmr_pkg::H_W-1:0] o_time_step,
    input logic                        o_no_finite_bound
);
    import cfl_tmr_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_time_step) && $stable(o_no_finite_bound))
        else $error("result word changed while stalled");

    // an empty sweep reports the saturated step
    a_empty_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_finite_bound |-> o_time_step == OUT_MAX)
        else $error("empty sweep without saturated time step");

    // reset empties the output slot
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

    // a taken particle keeps the block busy for the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after a particle was taken");

endmodule

bind cfl_timestep_min_reduction cfl_tmr_chk u_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_time_step       (o_time_step),
    .o_no_finite_bound (o_no_finite_bound)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Courant time step reduction: directed rows and random particle sweeps,
// with each emitted minimum checked against a typed expectation or an in-bench arithmetic predictor.
// ============================================================================
module testbench;
    import cfl_tmr_pkg::*;

    localparam int SETTLE_CYCLES = 600;     // slowest particle plus margin
    localparam int STALL_LIMIT   = 20000;   // cycles without any handshake
    localparam int HOLDOFF_LEN   = 3000;    // long receiver stall
    localparam int RANDOM_ITEMS  = 1830;

    typedef struct {
        logic [H_W-1:0]        h;
        logic [H_W-1:0]        cs;
        logic signed [G_W-1:0] sx, sy, sz;
        logic signed [G_W-1:0] gx, gy, gz;
        logic                  last;
    } t_sph_word;

    typedef struct {
        logic [H_W-1:0] ts;
        logic           nofin;
    } t_step;

    typedef struct {
        logic            is_cfg;
        t_reg_idx        idx;
        logic [CFL_W-1:0] data;
        t_sph_word       p;
        logic            typed;
        t_step           want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFL_W-1:0]      i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [H_W-1:0]        i_smoothing_length = '0;
    logic [H_W-1:0]        i_sound_speed = '0;
    logic signed [G_W-1:0] i_strain_rate_x = '0;
    logic signed [G_W-1:0] i_strain_rate_y = '0;
    logic signed [G_W-1:0] i_strain_rate_z = '0;
    logic signed [G_W-1:0] i_gravity_x = '0;
    logic signed [G_W-1:0] i_gravity_y = '0;
    logic signed [G_W-1:0] i_gravity_z = '0;
    logic                  i_last_particle = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [H_W-1:0]        o_time_step;
    logic                  o_no_finite_bound;

    cfl_timestep_min_reduction dut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state: configuration copy and sweep minimum
    logic [CFL_W-1:0] cfg_cfl = CFL_RESET;
    logic             cfg_grav = 1'b0;
    logic [31:0]      sweep_min = '1;
    logic             sweep_bound_seen = 1'b0;

    t_step     pending_steps[$];
    t_row      rows[$];
    int        mismatches = 0;
    int        particles_sent = 0;
    int        sweeps_checked = 0;
    int        settings_used = 0;
    int        idle_cycles = 0;
    int        hold_req = 0;
    logic      in_fire, out_fire;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatches++;
    endtask

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r, b;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // (a*b) >> FRACTION_BITS, saturated to the output range
    function automatic logic [63:0] scale_sat(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = (128'(a) * 128'(b)) >> FRACTION_BITS;
        return (p > 128'(OUT_MAX)) ? 64'(OUT_MAX) : p[63:0];
    endfunction

    function automatic void fold_bound(input logic [63:0] b);
        if (b < 64'(sweep_min)) sweep_min = b[31:0];
        sweep_bound_seen = 1'b1;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [G_W-1:0] v);
        longint s;
        s = longint'(v);
        return (s < 0) ? 64'(-s) : 64'(s);
    endfunction

    // fold one particle into the sweep; queue a step on the last one
    function automatic void predict_particle(input t_sph_word p, input logic typed,
                                             input t_step want);
        longint      tr;
        logic [63:0] atr, den, gsq, gm, num, q1, r1, q2, s;
        t_step       st;
        tr  = longint'(p.sx) + longint'(p.sy) + longint'(p.sz);
        atr = (tr < 0) ? 64'(-tr) : 64'(tr);
        den = 64'(p.cs) + ((64'(p.h) * atr) >> FRACTION_BITS);
        if (den != 0) fold_bound(scale_sat(64'(cfg_cfl), (64'(p.h) << FRACTION_BITS) / den));
        if (cfg_grav) begin
            gsq = mag64(p.gx) * mag64(p.gx) + mag64(p.gy) * mag64(p.gy)
                + mag64(p.gz) * mag64(p.gz);
            gm = int_sqrt(gsq);
            if (gm != 0) begin
                num = 64'(p.h) << FRACTION_BITS;
                q1  = num / gm;
                r1  = num % gm;
                if (q1 >= (64'd1 << (64 - FRACTION_BITS)) - 1) begin
                    s = 64'd1 << 32;
                end else begin
                    q2 = (q1 << FRACTION_BITS) + (r1 << FRACTION_BITS) / gm;
                    s  = int_sqrt(q2);
                end
                fold_bound(scale_sat(64'(cfg_cfl), s));
            end
        end
        if (!p.last) return;
        st.ts    = sweep_bound_seen ? sweep_min[H_W-1:0] : OUT_MAX;
        st.nofin = !sweep_bound_seen;
        pending_steps.push_back(typed ? want : st);
        sweep_min = '1;
        sweep_bound_seen = 1'b0;
    endfunction

    // offer one word and hold it until taken; returns at the next falling edge
    task automatic drive_particle(input t_sph_word p, input logic typed, input t_step want);
        i_smoothing_length = p.h;
        i_sound_speed      = p.cs;
        i_strain_rate_x    = p.sx;
        i_strain_rate_y    = p.sy;
        i_strain_rate_z    = p.sz;
        i_gravity_x        = p.gx;
        i_gravity_y        = p.gy;
        i_gravity_z        = p.gz;
        i_last_particle    = p.last;
        i_in_valid         = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_particle(p, typed, want);
        particles_sent++;
        @(negedge i_clk);
    endtask

    // drain, let the block finish any non-last particle, then write
    task automatic write_reg(input t_reg_idx idx, input logic [CFL_W-1:0] data);
        i_in_valid = 1'b0;
        while (pending_steps.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_CFL_FACTOR) cfg_cfl = data;
        else cfg_grav = data[0];
        settings_used++;
    endtask

    function automatic t_sph_word mk(input logic [H_W-1:0] h, input logic [H_W-1:0] cs,
                                     input logic [G_W-1:0] sx, input logic [G_W-1:0] sy,
                                     input logic [G_W-1:0] sz, input logic [G_W-1:0] gx,
                                     input logic [G_W-1:0] gy, input logic [G_W-1:0] gz,
                                     input logic last);
        t_sph_word p;
        p.h = h; p.cs = cs; p.sx = sx; p.sy = sy; p.sz = sz;
        p.gx = gx; p.gy = gy; p.gz = gz; p.last = last;
        return p;
    endfunction

    function automatic void add_item(input t_sph_word p, input logic typed,
                                     input logic [H_W-1:0] ts, input logic nofin);
        t_row r;
        r.is_cfg = 1'b0; r.idx = REG_CFL_FACTOR; r.data = '0; r.p = p;
        r.typed = typed; r.want.ts = ts; r.want.nofin = nofin;
        rows.push_back(r);
    endfunction

    function automatic void add_cfg(input t_reg_idx idx, input logic [CFL_W-1:0] data);
        t_row r;
        r.is_cfg = 1'b1; r.idx = idx; r.data = data; r.p = mk(0, 0, 0, 0, 0, 0, 0, 0, 0);
        r.typed = 1'b0; r.want.ts = '0; r.want.nofin = 1'b0;
        rows.push_back(r);
    endfunction

    function automatic logic [H_W-1:0] pick_unsigned();
        case ($urandom_range(0, 5))
            0, 1: return H_W'($urandom);
            2, 3: return H_W'($urandom_range(0, 32'h3_FFFF));
            4:    return H_W'($urandom_range(0, 32'hFF));
            default: return '0;
        endcase
    endfunction

    function automatic logic [G_W-1:0] pick_signed();
        case ($urandom_range(0, 5))
            0, 1: return G_W'($urandom);
            2, 3: return G_W'($urandom_range(0, 32'h4_0000)) - G_W'(32'h2_0000);
            4:    return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return '0;
        endcase
    endfunction

    // receiver: long hold-off on request, otherwise a shifting stall pattern
    int holdoff = 0;
    int rx_cycle = 0;
    always @(negedge i_clk) begin
        rx_cycle++;
        if (hold_req != 0) begin
            holdoff  = HOLDOFF_LEN;
            hold_req = 0;
        end
        if (holdoff > 0) begin
            holdoff--;
            i_out_ready <= 1'b0;
        end else begin
            case ((rx_cycle / 700) % 3)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 9) < 7);
                default: i_out_ready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    // check each taken result against the oldest pending step
    always @(posedge i_clk) begin
        in_fire  = i_in_valid && o_in_ready;
        out_fire = o_out_valid && i_out_ready;
        if (out_fire) begin
            if (pending_steps.size() == 0) begin
                report_mismatch("unexpected word", o_time_step, 0);
            end else begin
                if (o_time_step !== pending_steps[0].ts)
                    report_mismatch("time_step", o_time_step, pending_steps[0].ts);
                if (o_no_finite_bound !== pending_steps[0].nofin)
                    report_mismatch("no_finite_bound", o_no_finite_bound,
                                    pending_steps[0].nofin);
                void'(pending_steps.pop_front());
                sweeps_checked++;
            end
        end
        // watchdog on handshake progress
        if (in_fire || out_fire || !i_rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_sph_word p;
        t_step     none;
        int        burst_left, gap, sweep_len, n;
        logic [CFL_W-1:0] cfl_set[5];
        logic             grav_set[5];
        none.ts = '0; none.nofin = 1'b0;

        // directed rows at the reset settings
        add_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 1), 1, OUT_MAX, 1);          // empty sweep
        add_item(mk(OUT_MAX, 1, 0, 0, 0, 0, 0, 0, 1), 1, OUT_MAX, 0);    // saturated bound
        add_item(mk(0, OUT_MAX, 0, 0, 0, 0, 0, 0, 1), 1, 0, 0);          // zero length
        add_item(mk(1, 0, 1, 0, 0, 0, 0, 0, 1), 1, OUT_MAX, 1);          // divisor truncates to 0
        add_item(mk(OUT_MAX, OUT_MAX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0), 0, 0, 0);
        add_item(mk(OUT_MAX, OUT_MAX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1), 0, 0, 0);
        add_item(mk(31'h1_0000, 31'h1_0000, 32'h8000, -32'sh4000, 0, 0, 0, 0, 1), 0, 0, 0);
        add_item(mk(OUT_MAX, 0, 1, 0, 0, 0, 0, 0, 1), 0, 0, 0);
        // gravity on, unity factor
        add_cfg(REG_SELF_GRAVITY, 1);
        add_cfg(REG_CFL_FACTOR, 17'h1_0000);
        add_item(mk(31'h1_0000, 0, 0, 0, 0, 0, 0, 0, 1), 1, OUT_MAX, 1); // zero gravity
        add_item(mk(31'h1_0000, 0, 0, 0, 0, 32'h1_0000, 0, 0, 1), 1, 31'h1_0000, 0);
        add_item(mk(OUT_MAX, 5, 0, 0, 0, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 1), 0, 0, 0);
        add_item(mk(OUT_MAX, 0, 0, 0, 0, 1, 0, 0, 1), 0, 0, 0);
        add_item(mk(31'h3_0000, 31'h2_0000, 32'h1_0000, 0, 0, 0, 32'h4_0000, 0, 0), 0, 0, 0);
        add_item(mk(31'h8000, 31'h100, -32'sh2_0000, 32'h10, 0, 32'h300, 0, -32'sh9, 0),
                 0, 0, 0);
        add_item(mk(31'h2_0000, 31'h7_0000, 0, 32'h5_0000, -32'sh1, 0, 0, 32'h77, 1), 0, 0, 0);
        // zero factor, then out-of-range factor without gravity
        add_cfg(REG_CFL_FACTOR, 0);
        add_item(mk(31'h1_0000, 31'h1_0000, 0, 0, 0, 32'h10, 0, 0, 1), 1, 0, 0);
        add_cfg(REG_CFL_FACTOR, 17'h1_FFFF);
        add_cfg(REG_SELF_GRAVITY, 0);
        add_item(mk(31'h4_0000, 31'h1_0000, 32'h1000, 0, 0, 0, 0, 0, 1), 0, 0, 0);

        // reset, then walk the directed rows
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (rows[k]) begin
            if (rows[k].is_cfg) write_reg(rows[k].idx, rows[k].data);
            else drive_particle(rows[k].p, rows[k].typed, rows[k].want);
        end

        // random sweeps across several settings
        cfl_set  = '{CFL_RESET, 17'h1_0000, 17'h0_0001, 17'h1_FFFF, 17'h0_0000};
        grav_set = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        cfl_set[4] = CFL_W'($urandom_range(1, 17'h1_FFFF));
        burst_left = 0;
        sweep_len  = 0;
        n = 0;
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_CFL_FACTOR, cfl_set[ph]);
            write_reg(REG_SELF_GRAVITY, grav_set[ph]);
            for (int j = 0; j < RANDOM_ITEMS / 5; j++) begin
                n++;
                if (n == 300) hold_req = 1;           // long receiver stall
                if (n == 900) begin                   // sender drains everything
                    i_in_valid = 1'b0;
                    while (pending_steps.size() != 0) @(negedge i_clk);
                end
                if (sweep_len == 0) sweep_len = ($urandom_range(0, 3) == 0)
                                                ? $urandom_range(1, 20) : $urandom_range(1, 4);
                p.h = pick_unsigned();   p.cs = pick_unsigned();
                p.sx = pick_signed();    p.sy = pick_signed();   p.sz = pick_signed();
                p.gx = pick_signed();    p.gy = pick_signed();   p.gz = pick_signed();
                sweep_len--;
                p.last = (sweep_len == 0);
                drive_particle(p, 1'b0, none);
                // bursts with gaps, and quiet stretches with none
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap = ((n / 150) % 3 == 0) ? 0 : $urandom_range(1, 20);
                    if (gap != 0) begin
                        i_in_valid = 1'b0;
                        repeat (gap) @(negedge i_clk);
                    end
                end else begin
                    burst_left--;
                end
            end
        end
        i_in_valid = 1'b0;

        while (pending_steps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d particles in %0d checked sweeps", particles_sent, sweeps_checked);
        $display("over %0d register writes, gravity on and off, factor 0 to 0x1FFFF",
                 settings_used);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
